### design/sspg_pkg.sv
// Shared types and constants for the stepper step pulse generator.
// No dependencies; every other design file refers to this package by scoped names.
package sspg_pkg;

    // Microseconds in one minute: the dividend of the step period division
    localparam int unsigned US_PER_MINUTE = 60 * 1000 * 1000;

    // Quotient bits needed to hold US_PER_MINUTE
    localparam int unsigned QUOT_W = 26;

    // Divisor is steps_per_rev times |speed|, 16 x 16 bits
    localparam int unsigned DIVISOR_W = 32;

    localparam logic [QUOT_W-1:0] DIVIDEND = QUOT_W'(US_PER_MINUTE);

    // Steps per revolution after reset
    localparam logic [15:0] SPR_RESET = 16'd200;

    // Item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic exec_imm;    // apply a tick or a zero-speed command now
        logic latch_move;  // capture operands of a move command
        logic mul_load;    // form the divisor and seed the divider
        logic div_step;    // one restoring division step
        logic finish;      // commit the move command
    } sspg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic imm;         // current input item needs no division
    } sspg_status_t;

endpackage

### design/sspg_datapath.sv
// Datapath of the stepper step pulse generator: motion state, tick logic,
// bit-serial period divider and result registers. Depends on sspg_pkg.
module sspg_datapath #(
    parameter int PERIOD_WIDTH = 26
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_wdata,
    input  logic                     opcode,
    input  logic [15:0]              step_count,
    input  logic signed [15:0]       speed_rpm,
    input  sspg_pkg::sspg_cmd_t      cmd,
    output sspg_pkg::sspg_status_t   status,
    output logic                     step_strobe,
    output logic                     direction,
    output logic [15:0]              position,
    output logic [15:0]              steps_remaining,
    output logic                     running
);

    localparam int unsigned QW    = sspg_pkg::QUOT_W;
    localparam int unsigned DW    = sspg_pkg::DIVISOR_W;
    localparam int unsigned CMP_W = (PERIOD_WIDTH > QW) ? PERIOD_WIDTH : QW;
    localparam logic [PERIOD_WIDTH-1:0] PMAX = {PERIOD_WIDTH{1'b1}};

    // Configuration and motion state
    logic [15:0]             spr_reg;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic [PERIOD_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [15:0]             left_reg, left_next;
    logic                    cont_reg, cont_next;
    logic                    dir_reg, dir_next;
    logic [15:0]             pos_reg, pos_next;

    // Move operands and divider
    logic [15:0]             count_reg;
    logic                    neg_reg;
    logic [15:0]             mag_reg;
    logic [DW-1:0]           divisor_reg;
    logic [DW-1:0]           rem_reg, rem_next;
    logic [QW-1:0]           quo_reg, quo_next;

    // Result registers
    logic                    out_strobe_reg, out_strobe_next;
    logic                    out_dir_reg;
    logic [15:0]             out_pos_reg;
    logic [15:0]             out_left_reg;
    logic                    out_run_reg;

    logic [15:0]             spr_eff;
    logic [15:0]             speed_raw;
    logic [15:0]             speed_mag;
    logic                    active;
    logic [PERIOD_WIDTH-1:0] elapsed_inc;
    logic                    hit;
    logic [15:0]             pos_fwd, pos_rev;
    logic [DW:0]             trial;
    logic                    ge;
    logic [CMP_W-1:0]        quo_ext;
    logic [PERIOD_WIDTH-1:0] period_new;

    // Decode the incoming item
    assign spr_eff    = (spr_reg == 16'd0) ? 16'd1 : spr_reg;
    assign speed_raw  = speed_rpm;
    assign speed_mag  = speed_raw[15] ? (~speed_raw + 16'd1) : speed_raw;
    assign status.imm = (opcode == sspg_pkg::OP_TICK) || (speed_mag == 16'd0);

    // Tick arithmetic: saturating elapsed time, reach test, position wrap
    assign active      = cont_reg || (left_reg != 16'd0);
    assign elapsed_inc = (elapsed_reg != PMAX) ? elapsed_reg + PERIOD_WIDTH'(1) : elapsed_reg;
    assign hit         = active && (elapsed_inc >= period_reg);
    assign pos_fwd     = ({1'b0, pos_reg} + 17'd1 >= {1'b0, spr_eff}) ? 16'd0
                                                                      : pos_reg + 16'd1;
    assign pos_rev     = (pos_reg == 16'd0) ? spr_eff - 16'd1 : pos_reg - 16'd1;

    // Restoring division step
    assign trial    = {rem_reg, quo_reg[QW-1]};
    assign ge       = trial >= {1'b0, divisor_reg};
    assign rem_next = ge ? DW'(trial - {1'b0, divisor_reg}) : trial[DW-1:0];
    assign quo_next = {quo_reg[QW-2:0], ge};

    // Saturate the quotient to the period width, clamp zero to one
    always_comb
    begin
        quo_ext = CMP_W'(quo_reg);
        if (quo_ext > CMP_W'(PMAX))
        begin
            period_new = PMAX;
        end
        else if (quo_reg == '0)
        begin
            period_new = PERIOD_WIDTH'(1);
        end
        else
        begin
            period_new = quo_ext[PERIOD_WIDTH-1:0];
        end
    end

    // Next motion state
    always_comb
    begin
        period_next     = period_reg;
        elapsed_next    = elapsed_reg;
        left_next       = left_reg;
        cont_next       = cont_reg;
        dir_next        = dir_reg;
        pos_next        = pos_reg;
        out_strobe_next = 1'b0;
        if (cmd.exec_imm)
        begin
            if (opcode == sspg_pkg::OP_MOVE)
            begin
                // zero speed: stop, keep period, direction and position
                cont_next = 1'b0;
                left_next = 16'd0;
            end
            else if (active)
            begin
                elapsed_next = elapsed_inc;
                if (hit)
                begin
                    out_strobe_next = 1'b1;
                    elapsed_next    = elapsed_inc - period_reg;
                    if (!cont_reg)
                    begin
                        left_next = left_reg - 16'd1;
                    end
                    pos_next = dir_reg ? pos_fwd : pos_rev;
                end
            end
        end
        else if (cmd.finish)
        begin
            period_next  = period_new;
            elapsed_next = '0;
            left_next    = count_reg;
            cont_next    = (count_reg == 16'd0);
            dir_next     = !neg_reg;
        end
    end

    // Configuration and motion state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg     <= sspg_pkg::SPR_RESET;
            period_reg  <= '0;
            elapsed_reg <= '0;
            left_reg    <= 16'd0;
            cont_reg    <= 1'b0;
            dir_reg     <= 1'b0;
            pos_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                spr_reg <= cfg_wdata;
            end
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
            left_reg    <= left_next;
            cont_reg    <= cont_next;
            dir_reg     <= dir_next;
            pos_reg     <= pos_next;
        end
    end

    // Operands, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_move)
        begin
            count_reg <= step_count;
            neg_reg   <= speed_raw[15];
            mag_reg   <= speed_mag;
        end
        if (cmd.mul_load)
        begin
            divisor_reg <= spr_eff * mag_reg;
            rem_reg     <= '0;
            quo_reg     <= sspg_pkg::DIVIDEND;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.exec_imm || cmd.finish)
        begin
            out_strobe_reg <= out_strobe_next;
            out_dir_reg    <= dir_next;
            out_pos_reg    <= pos_next;
            out_left_reg   <= left_next;
            out_run_reg    <= cont_next || (left_next != 16'd0);
        end
    end

    assign step_strobe     = out_strobe_reg;
    assign direction       = out_dir_reg;
    assign position        = out_pos_reg;
    assign steps_remaining = out_left_reg;
    assign running         = out_run_reg;

endmodule

### design/sspg_ctrl.sv
// Controller of the stepper step pulse generator: handshakes and the
// sequence of a move command through the divider. Depends on sspg_pkg.
module sspg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  sspg_pkg::sspg_status_t  status,
    output sspg_pkg::sspg_cmd_t     cmd
);

    localparam int unsigned CNT_W = $clog2(sspg_pkg::QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(sspg_pkg::QUOT_W - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             load_out;

    // Take an item only when idle and the result register is free or draining
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Sequence
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.imm)
                    begin
                        cmd.exec_imm = 1'b1;
                    end
                    else
                    begin
                        cmd.latch_move = 1'b1;
                        state_next     = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until transferred
    assign load_out = cmd.exec_imm || cmd.finish;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A move command produces no result until the divider is done
    a_move_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !status.imm) |=> !out_valid_reg)
        else $error("move command result appeared before division finished");

    // The step counter never runs past the last quotient bit
    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= LAST_STEP))
        else $error("divider step count out of range");

    // A result is only loaded into a free or draining result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    // Commit always returns to idle
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after commit");

endmodule

### design/stepper_step_pulse_generator_unit.sv
// Stepper step pulse generator: a tick, or a move command with zero speed, is
// applied in the cycle it is transferred and its result is ready on the next
// cycle; a move command with nonzero speed passes through operand capture,
// one multiply of steps_per_rev by |speed|, 26 steps of the bit-serial
// restoring divider forming 60000000 / (steps_per_rev * |speed|), and commit.
// One item is in flight at a time; the result register lets the next item be
// transferred in the same cycle the previous result is taken.
// Depends on sspg_pkg, sspg_ctrl and sspg_datapath.
module stepper_step_pulse_generator_unit #(
    parameter int PERIOD_WIDTH = 26
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [15:0]        step_count,
    input  logic signed [15:0] speed_rpm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               step_strobe,
    output logic               direction,
    output logic [15:0]        position,
    output logic [15:0]        steps_remaining,
    output logic               running
);

    sspg_pkg::sspg_cmd_t    cmd;
    sspg_pkg::sspg_status_t status;

    // Sequencer
    sspg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Motion state, divider and results
    sspg_datapath #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .opcode          (opcode),
        .step_count      (step_count),
        .speed_rpm       (speed_rpm),
        .cmd             (cmd),
        .status          (status),
        .step_strobe     (step_strobe),
        .direction       (direction),
        .position        (position),
        .steps_remaining (steps_remaining),
        .running         (running)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for stepper_step_pulse_generator_unit: directed and random
// move commands and microsecond ticks, each result checked against an in-bench motor model or a fixed expected result.
// Depends on sspg_pkg and the design files under design/.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PHASE_ITEMS  = 255;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam logic [25:0] PERIOD_MAX   = '1;

    // One result as seen on the output ports
    typedef struct packed {
        logic        strobe;
        logic        dir;
        logic [15:0] pos;
        logic [15:0] rem;
        logic        run;
    } motor_out_t;

    // One row of the directed script; fixed holds the result where it is obvious
    typedef struct packed {
        logic              op;
        logic [15:0]       cnt;
        logic signed [15:0] spd;
        logic [7:0]        reps;
        logic              known;
        motor_out_t        fixed;
    } script_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               opcode = sspg_pkg::OP_TICK;
    logic [15:0]        step_count = '0;
    logic signed [15:0] speed_rpm = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               step_strobe;
    logic               direction;
    logic [15:0]        position;
    logic [15:0]        steps_remaining;
    logic               running;

    // Motor model state
    logic [15:0] mdl_spr = sspg_pkg::SPR_RESET;
    logic [25:0] mdl_period = '0;
    logic [25:0] mdl_elapsed = '0;
    logic [15:0] mdl_left = '0;
    logic        mdl_cont = 1'b0;
    logic        mdl_dir = 1'b0;
    logic [15:0] mdl_pos = '0;

    motor_out_t  pending_outputs[$];
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;

    script_row_t script[8] = '{
        '{sspg_pkg::OP_TICK, 16'd0,    16'sd0,     8'd1,  1'b1, '0},
        '{sspg_pkg::OP_MOVE, 16'd5,    16'sd0,     8'd1,  1'b1, '0},
        '{sspg_pkg::OP_MOVE, 16'd2,    16'sd32767, 8'd1,  1'b1, '{1'b0, 1'b1, 16'd0, 16'd2, 1'b1}},
        '{sspg_pkg::OP_TICK, 16'hFFFF, 16'sd0,     8'd9,  1'b0, '0},
        '{sspg_pkg::OP_MOVE, 16'd0,    16'h8000,   8'd1,  1'b0, '0},
        '{sspg_pkg::OP_TICK, 16'd0,    16'h7FFF,   8'd10, 1'b0, '0},
        '{sspg_pkg::OP_MOVE, 16'hFFFF, 16'sd0,     8'd1,  1'b0, '0},
        '{sspg_pkg::OP_TICK, 16'd0,    16'sd0,     8'd1,  1'b0, '0}
    };

    stepper_step_pulse_generator_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .step_count      (step_count),
        .speed_rpm       (speed_rpm),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .step_strobe     (step_strobe),
        .direction       (direction),
        .position        (position),
        .steps_remaining (steps_remaining),
        .running         (running)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one item to the motor model and return the result it yields
    function automatic motor_out_t advance_motor(logic op, logic [15:0] cnt,
                                                 logic [15:0] spd);
        logic [16:0]     mag;
        logic [31:0]     spr_eff;
        longint unsigned quot;
        motor_out_t      r;
        mag = spd[15] ? (17'h10000 - {1'b0, spd}) : {1'b0, spd};
        spr_eff = (mdl_spr == 16'd0) ? 32'd1 : {16'd0, mdl_spr};
        r.strobe = 1'b0;
        if (op == sspg_pkg::OP_MOVE)
        begin
            mdl_cont = (cnt == 16'd0) && (mag != 17'd0);
            if (mag != 17'd0)
            begin
                quot = longint'(sspg_pkg::US_PER_MINUTE) / spr_eff / mag;
                if (quot > PERIOD_MAX)
                    quot = PERIOD_MAX;
                if (quot == 0)
                    quot = 1;
                mdl_period  = quot[25:0];
                mdl_dir     = !spd[15];
                mdl_left    = cnt;
                mdl_elapsed = '0;
            end
            else
                mdl_left = '0;
        end
        else if (mdl_cont || mdl_left != 16'd0)
        begin
            if (mdl_elapsed < PERIOD_MAX)
                mdl_elapsed++;
            // Issue a step once the period is reached, keeping the phase
            if (mdl_elapsed >= mdl_period)
            begin
                r.strobe = 1'b1;
                mdl_elapsed -= mdl_period;
                if (!mdl_cont)
                    mdl_left--;
                if (mdl_dir)
                    mdl_pos = ({16'd0, mdl_pos} + 32'd1 >= spr_eff) ? 16'd0 : mdl_pos + 16'd1;
                else
                    mdl_pos = (mdl_pos == 16'd0) ? spr_eff[15:0] - 16'd1 : mdl_pos - 16'd1;
            end
        end
        r.dir = mdl_dir;
        r.pos = mdl_pos;
        r.rem = mdl_left;
        r.run = mdl_cont || (mdl_left != 16'd0);
        return r;
    endfunction

    // Offer one item from a falling edge, hold it until transferred, log its result
    task automatic transfer_item(input logic op, input logic [15:0] cnt,
                                 input logic [15:0] spd, input logic known,
                                 input motor_out_t fixed);
        motor_out_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        step_count <= cnt;
        speed_rpm  <= spd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_motor(op, cnt, spd);
        pending_outputs.push_back(known ? fixed : predicted);
        @(negedge clk);
    endtask

    // Drop valid and wait until every logged result has come back
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write steps_per_rev while the block is idle
    task automatic write_spr(input logic [15:0] value);
        drain_outputs();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mdl_spr = value;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Receiver: long hold-off when asked, else random stall
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each transferred result with the oldest logged one
    always @(posedge clk)
    begin
        motor_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result with no item outstanding");
                err_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                check_field("step_strobe", want.strobe, step_strobe);
                check_field("direction", want.dir, direction);
                check_field("position", want.pos, position);
                check_field("steps_remaining", want.rem, steps_remaining);
                check_field("running", want.run, running);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int unsigned   spr_plan[NUM_PHASES];
        int unsigned   idle_plan[NUM_PHASES];
        int unsigned   stall_plan[NUM_PHASES];
        logic          op;
        logic [15:0]   cnt;
        logic [15:0]   spd;
        logic [15:0]   mag;
        int unsigned   pick;

        spr_plan   = '{200, 65535, 0, 1, 13, $urandom_range(2, 65534)};
        idle_plan  = '{0, 55, 0, 24, 0, 55};
        stall_plan = '{0, 0, 55, 24, 0, 55};

        // Hold reset, then release it
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed script
        foreach (script[r])
            for (int n = 0; n < script[r].reps; n++)
                transfer_item(script[r].op, script[r].cnt, script[r].spd,
                              script[r].known, script[r].fixed);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
                write_spr(spr_plan[ph][15:0]);
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            // Hold off the receiver long enough to back up the input side
            if (ph == 2)
                hold_left = 400;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    drain_outputs();
                op  = ($urandom_range(99) < 10) ? sspg_pkg::OP_MOVE : sspg_pkg::OP_TICK;
                cnt = 16'($urandom);
                spd = 16'($urandom);
                if (op == sspg_pkg::OP_MOVE)
                begin
                    // Mostly short counted moves, some continuous, some wide counts
                    pick = $urandom_range(99);
                    if (pick < 15)
                        cnt = '0;
                    else if (pick < 75)
                        cnt = 16'($urandom_range(1, 8));
                    // Mostly fast speeds so that steps come often
                    pick = $urandom_range(99);
                    if (pick < 6)
                        spd = '0;
                    else if (pick < 75)
                    begin
                        mag = 16'($urandom_range(4096, 32767));
                        spd = $urandom_range(1) ? -mag : mag;
                    end
                end
                transfer_item(op, cnt, spd, 1'b0, '0);
            end
        end

        // Drain and settle
        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
